// ===== rtl/wsbh_pkg.sv =====
// Shared types and constants for the weighted square byte hash.
// Used by wsbh_ctrl, wsbh_dp and weighted_square_byte_hash; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wsbh_pkg;

  // Per-quarter weighting factors
  localparam logic [40:0] FACTOR_Q0 = 41'h1070601686f;
  localparam logic [40:0] FACTOR_Q1 = 41'h0405236496f;
  localparam logic [40:0] FACTOR_Q2 = 41'h1966822847f;
  localparam logic [40:0] FACTOR_Q3 = 41'h0732464301f;

  // Finalisation: multiply (mod 2^64), then divide by a constant
  localparam logic [34:0] FINAL_MUL = 35'h666666666;
  localparam logic [25:0] FINAL_DIV = 26'd40744667;

  // floor(2^64 / FINAL_DIV); the estimate it gives is low by at most one
  localparam logic [38:0] FINAL_RCP = 39'd452740086787;

  // Message quarter codes
  localparam logic [1:0] QTR_0 = 2'd0;
  localparam logic [1:0] QTR_1 = 2'd1;
  localparam logic [1:0] QTR_2 = 2'd2;
  localparam logic [1:0] QTR_3 = 2'd3;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_in;   // capture the input word
    logic prep;      // square the byte, pick the quarter, flag last byte
    logic clear;     // zero-length word: clear state, result is zero
    logic mult;      // weight the shifted square
    logic accum;     // add into the running sum
    logic fmul_lo;   // low half of the final multiply
    logic fmul_hi;   // high half of the final multiply, low reciprocal product
    logic rcp;       // high reciprocal product, quotient estimate
    logic fix;       // remainder of the quotient estimate
    logic load_out;  // move the corrected quotient into the output register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic len_zero;  // captured length is zero
    logic last;      // current byte closes the message
    logic out_free;  // output register can take a word this cycle
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/weighted_square_byte_hash.sv =====
// Top level of the weighted square byte hash: controller plus datapath.
// Depends on wsbh_pkg, wsbh_ctrl and wsbh_dp.
`timescale 1ns / 1ps
`default_nettype none

// Hashes a message one signed byte per input word, with the message length
// carried on every word; only the low LENGTH_BITS bits of the length count.
// One word is in flight at a time. A byte that does not close the message
// goes through capture, square and quarter select, weighting multiply and
// 64-bit add before the next word is accepted. The closing byte goes through
// the same steps, then the two halves of the 64-bit final product on one
// shared 32x35 multiplier, the end of the reciprocal multiply that estimates
// the quotient, the estimate's remainder and the loading of the corrected
// hash, plus any wait for the output register. A zero-length word is
// captured, clears the state, loads a zero hash and drops any message in
// progress. The output register lets a new word be accepted while a hash
// waits to be taken.
module weighted_square_byte_hash #(
  parameter int LENGTH_BITS = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  data_byte,
  input  wire  [15:0] total_length,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [38:0] hash_value
);

  import wsbh_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  wsbh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Arithmetic and state
  wsbh_dp #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .data_byte    (data_byte),
    .total_length (total_length),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .hash_value   (hash_value)
  );

endmodule

`default_nettype wire

// ===== rtl/wsbh_dp.sv =====
// Datapath of the weighted square byte hash: byte weighting, running sum,
// final multiply, reciprocal divider and output register. Uses wsbh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsbh_dp #(
  parameter int LENGTH_BITS = 16
) (
  input  wire              clk,
  input  wire              rst,
  input  wsbh_pkg::cmd_t   cmd,
  output wsbh_pkg::sts_t   sts,
  input  wire  [7:0]       data_byte,
  input  wire  [15:0]      total_length,
  input  wire              out_stall,
  output logic             out_valid,
  output logic [38:0]      hash_value
);

  import wsbh_pkg::*;

  // Compare width: wide enough for the index and for 3*length
  localparam int CW = (LENGTH_BITS > 18) ? LENGTH_BITS : 18;
  localparam logic [15:0] LEN_MASK =
    (LENGTH_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << LENGTH_BITS) - 32'd1);

  // Captured input word
  logic [7:0]             byte_reg;
  logic [15:0]            len_reg;

  // Hash state
  logic [LENGTH_BITS-1:0] byte_index;
  logic [63:0]            running_sum;

  // Intermediate registers
  logic [18:0]            sq_sh;
  logic [1:0]             quarter;
  logic                   last_flag;
  logic [63:0]            prod;
  logic [63:0]            fin_acc;
  logic [63:0]            fin_prod;
  logic [63:0]            mix;      // final product mod 2^64
  logic [38:0]            rcp_lo;   // upper bits of the low reciprocal product
  logic [38:0]            quot;     // quotient estimate, low by at most one
  logic [26:0]            resid;    // remainder of the estimate, below 2*divisor

  // Combinational terms
  logic [7:0]             mag;
  logic [15:0]            sq;
  logic [18:0]            sq19;
  logic [CW-1:0]          idx_x;
  logic [CW-1:0]          len_x;
  logic [CW-1:0]          bound_q1;
  logic [CW-1:0]          bound_q2;
  logic [CW-1:0]          bound_q3;
  logic [1:0]             quarter_next;
  logic [18:0]            sq_sh_next;
  logic                   last_next;
  logic [40:0]            factor;
  logic [59:0]            wmul;
  logic [63:0]            sum_new;
  logic [31:0]            fm_a;
  logic [66:0]            fm_p;
  logic [31:0]            rc_a;
  logic [70:0]            rc_p;
  logic [70:0]            rc_sum;
  logic [26:0]            qd_lo;
  logic                   resid_ge;

  // Square of the byte magnitude; -128 gives 128
  assign mag  = byte_reg[7] ? (~byte_reg + 8'd1) : byte_reg;
  assign sq   = {8'd0, mag} * {8'd0, mag};
  assign sq19 = {3'd0, sq};

  // Quarter boundaries from the current length
  assign idx_x    = CW'(byte_index);
  assign len_x    = CW'(len_reg);
  assign bound_q1 = len_x >> 2;
  assign bound_q2 = len_x >> 1;
  assign bound_q3 = (len_x + (len_x << 1)) >> 2;

  always_comb begin
    if (idx_x < bound_q1) begin
      quarter_next = QTR_0;
    end else if (idx_x < bound_q2) begin
      quarter_next = QTR_1;
    end else if (idx_x < bound_q3) begin
      quarter_next = QTR_2;
    end else begin
      quarter_next = QTR_3;
    end
  end

  always_comb begin
    case (quarter_next)
      QTR_0:   sq_sh_next = sq19 >> 5;
      QTR_1:   sq_sh_next = sq19 << 2;
      QTR_2:   sq_sh_next = sq19 >> 1;
      default: sq_sh_next = sq19 << 4;
    endcase
  end

  assign last_next = ({1'b0, idx_x} + {{CW{1'b0}}, 1'b1}) >= {1'b0, len_x};

  // Weighting multiply
  always_comb begin
    case (quarter)
      QTR_0:   factor = FACTOR_Q0;
      QTR_1:   factor = FACTOR_Q1;
      QTR_2:   factor = FACTOR_Q2;
      default: factor = FACTOR_Q3;
    endcase
  end

  assign wmul    = {41'd0, sq_sh} * {19'd0, factor};
  assign sum_new = running_sum + prod;

  // Shared 32x35 multiplier for the two halves of the final product
  assign fm_a = cmd.fmul_hi ? fin_acc[63:32] : fin_acc[31:0];
  assign fm_p = {35'd0, fm_a} * {32'd0, FINAL_MUL};

  // Shared 32x39 reciprocal multiplier: low half of the product (already in
  // fin_prod) during fmul_hi, high half of it during rcp
  assign rc_a   = cmd.rcp ? mix[63:32] : fin_prod[31:0];
  assign rc_p   = {39'd0, rc_a} * {32'd0, FINAL_RCP};
  assign rc_sum = rc_p + {32'd0, rcp_lo};

  // Remainder of the estimate needs only its low 27 bits
  assign qd_lo    = quot[26:0] * {1'b0, FINAL_DIV};
  assign resid_ge = resid >= {1'b0, FINAL_DIV};

  // Hash state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index  <= '0;
      running_sum <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.clear) begin
        byte_index  <= '0;
        running_sum <= '0;
      end else if (cmd.accum) begin
        if (last_flag) begin
          byte_index  <= '0;
          running_sum <= '0;
        end else begin
          byte_index  <= byte_index + LENGTH_BITS'(1);
          running_sum <= sum_new;
        end
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      byte_reg <= data_byte;
      len_reg  <= total_length & LEN_MASK;
    end
    if (cmd.prep) begin
      sq_sh     <= sq_sh_next;
      quarter   <= quarter_next;
      last_flag <= last_next;
    end
    if (cmd.mult) begin
      prod <= {4'd0, wmul};
    end
    if (cmd.accum) begin
      fin_acc <= sum_new;
    end
    if (cmd.fmul_lo) begin
      fin_prod <= fm_p[63:0];
    end
    if (cmd.fmul_hi) begin
      mix    <= fin_prod + {fm_p[31:0], 32'd0};
      rcp_lo <= rc_p[70:32];
    end
    if (cmd.clear) begin
      quot  <= '0;
      resid <= '0;
    end else begin
      if (cmd.rcp) begin
        quot <= rc_sum[70:32];
      end
      if (cmd.fix) begin
        resid <= mix[26:0] - qd_lo;
      end
    end
    if (cmd.load_out) begin
      hash_value <= quot + 39'(resid_ge);
    end
  end

  assign sts.len_zero = (len_reg == 16'd0);
  assign sts.last     = last_flag;
  assign sts.out_free = !out_valid || !out_stall;

endmodule

`default_nettype wire

// ===== rtl/wsbh_ctrl.sv =====
// Controller of the weighted square byte hash: sequences the datapath
// through weighting, accumulation and finalisation. Uses wsbh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsbh_ctrl (
  input  wire             clk,
  input  wire             rst,
  input  wire             in_valid,
  output logic            in_stall,
  input  wsbh_pkg::sts_t  sts,
  output wsbh_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_PREP    = 4'd1;
  localparam logic [3:0] S_MULT    = 4'd2;
  localparam logic [3:0] S_ACCUM   = 4'd3;
  localparam logic [3:0] S_FMUL_LO = 4'd4;
  localparam logic [3:0] S_FMUL_HI = 4'd5;
  localparam logic [3:0] S_RCP     = 4'd6;
  localparam logic [3:0] S_FIX     = 4'd7;
  localparam logic [3:0] S_FINISH  = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_stall = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_PREP;
        end
      end
      S_PREP: begin
        if (sts.len_zero) begin
          cmd.clear  = 1'b1;
          state_next = S_FINISH;
        end else begin
          cmd.prep   = 1'b1;
          state_next = S_MULT;
        end
      end
      S_MULT: begin
        cmd.mult   = 1'b1;
        state_next = S_ACCUM;
      end
      S_ACCUM: begin
        cmd.accum  = 1'b1;
        state_next = sts.last ? S_FMUL_LO : S_IDLE;
      end
      S_FMUL_LO: begin
        cmd.fmul_lo = 1'b1;
        state_next  = S_FMUL_HI;
      end
      S_FMUL_HI: begin
        cmd.fmul_hi = 1'b1;
        state_next  = S_RCP;
      end
      S_RCP: begin
        cmd.rcp    = 1'b1;
        state_next = S_FIX;
      end
      S_FIX: begin
        cmd.fix    = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for weighted_square_byte_hash: directed and random
// byte messages, with a word-level predictor and a queue of expected hashes.
// Depends only on the RTL top level; drives at falling edges, samples at rising.
`timescale 1ns / 1ps

module testbench;

  // Weighting per message quarter and the final mix
  localparam logic [63:0] WEIGHT_Q0 = 64'h1070601686f;
  localparam logic [63:0] WEIGHT_Q1 = 64'h0405236496f;
  localparam logic [63:0] WEIGHT_Q2 = 64'h1966822847f;
  localparam logic [63:0] WEIGHT_Q3 = 64'h0732464301f;
  localparam logic [63:0] MIX_MUL   = 64'h666666666;
  localparam logic [63:0] MIX_DIV   = 64'd40744667;

  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 150;

  typedef enum logic [2:0] {
    PH_FREE,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_BOTH,
    PH_PRESSURE
  } phase_e;

  typedef struct packed {
    logic [7:0]  msg_byte;
    logic [15:0] msg_len;
  } word_t;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte    = 8'd0;
  logic [15:0] total_length = 16'd0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic [38:0] hash_value;

  weighted_square_byte_hash #(
    .LENGTH_BITS(16)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .total_length (total_length),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .hash_value   (hash_value)
  );

  // Words waiting to be sent, hashes waiting to come out
  word_t       pending_words[$];
  logic [38:0] hash_expected[$];

  // Predictor state: position in the message and the wrapping weighted sum
  logic [15:0] msg_pos = 16'd0;
  logic [63:0] msg_sum = 64'd0;

  phase_e      phase          = PH_FREE;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          hold_left      = 0;
  bit          hold_used      = 1'b0;
  logic        in_taken       = 1'b0;
  int          mismatches     = 0;
  int          quiet_cycles   = 0;
  logic [38:0] hash_want;
  logic [38:0] hash_new;

  initial begin
    forever #5 clk = ~clk;
  end

  // Absorb one byte; returns 1 when the word closes a message (or has zero length)
  function automatic bit hash_absorb_byte(input logic [7:0] b, input logic [15:0] len,
                                          output logic [38:0] h);
    logic [7:0]  mag;
    logic [63:0] sq;
    logic [63:0] weight;
    logic [63:0] mixed;
    logic [63:0] len64;
    logic [63:0] pos64;
    h = '0;
    // zero length drops whatever message was in progress
    if (len == 16'd0) begin
      msg_pos = '0;
      msg_sum = '0;
      return 1'b1;
    end
    mag   = b[7] ? (8'd0 - b) : b;
    sq    = 64'(mag) * 64'(mag);
    len64 = 64'(len);
    pos64 = 64'(msg_pos);
    if (pos64 < len64 / 4)
      weight = (sq >> 5) * WEIGHT_Q0;
    else if (pos64 < len64 / 2)
      weight = (sq << 2) * WEIGHT_Q1;
    else if (pos64 < (len64 * 3) / 4)
      weight = (sq >> 1) * WEIGHT_Q2;
    else
      weight = (sq << 4) * WEIGHT_Q3;
    msg_sum = msg_sum + weight;
    // last byte, also when the length shrank below the current position
    if (pos64 + 64'd1 >= len64) begin
      mixed   = msg_sum * MIX_MUL;
      mixed   = mixed / MIX_DIV;
      h       = mixed[38:0];
      msg_pos = '0;
      msg_sum = '0;
      return 1'b1;
    end
    msg_pos = msg_pos + 16'd1;
    return 1'b0;
  endfunction

  task automatic push_word(input logic [7:0] b, input logic [15:0] len);
    word_t w;
    w.msg_byte = b;
    w.msg_len  = len;
    pending_words.push_back(w);
  endtask

  // Mostly whole messages with random bytes; some cut short, zero-length and noise words
  task automatic queue_random_words(input int count);
    int added;
    int kind;
    int len;
    int n;
    added = 0;
    while (added < count) begin
      kind = $urandom_range(0, 99);
      n    = $urandom_range(0, 99);
      if (n < 70)
        len = $urandom_range(1, 8);
      else if (n < 95)
        len = $urandom_range(9, 40);
      else
        len = $urandom_range(41, 200);
      if (kind < 80) begin
        n = len;
      end else if (kind < 90) begin
        n = (len > 1) ? $urandom_range(1, len - 1) : 1;
      end else if (kind < 95) begin
        len = 0;
        n   = 1;
      end else begin
        len = $urandom_range(0, 65535);
        n   = 1;
      end
      repeat (n) push_word(8'($urandom_range(0, 255)), 16'(len));
      added += n;
    end
  endtask

  task run_phase(input phase_e ph, input int send_pct, input int recv_pct, input int count);
    phase          = ph;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    queue_random_words(count);
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  // Sender: a new word only once the current one is taken
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        data_byte    <= pending_words[0].msg_byte;
        total_length <= pending_words[0].msg_len;
        in_valid     <= 1'b1;
        void'(pending_words.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off in the pressure phase
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (phase == PH_PRESSURE && !hold_used) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      hold_used <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Check hashes taken, then predict from words taken
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (hash_expected.size() == 0) begin
          $error("hash_value: expected nothing, got %0d", hash_value);
          mismatches++;
        end else begin
          hash_want = hash_expected.pop_front();
          if (hash_value !== hash_want) begin
            $error("hash_value: expected %0d, got %0d", hash_want, hash_value);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (hash_absorb_byte(data_byte, total_length, hash_new))
          hash_expected.push_back(hash_new);
      end
    end
    in_taken <= !rst && in_valid && !in_stall;
  end

  // Watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    // single-byte messages at both byte extremes
    push_word(8'h80, 16'd1);
    push_word(8'h7f, 16'd1);
    // zero length on its own
    push_word(8'h55, 16'd0);
    // one byte in each quarter
    push_word(8'h80, 16'd4);
    push_word(8'h7f, 16'd4);
    push_word(8'hff, 16'd4);
    push_word(8'h00, 16'd4);
    // zero length in the middle of a message
    push_word(8'h0a, 16'd5);
    push_word(8'h14, 16'd5);
    push_word(8'haa, 16'd0);
    // length shrinks below the position mid-message
    push_word(8'h01, 16'd8);
    push_word(8'h02, 16'd8);
    push_word(8'h03, 16'd8);
    push_word(8'h04, 16'd2);
    // largest length, closed by a shorter one
    push_word(8'h7f, 16'hffff);
    push_word(8'h80, 16'd1);
    // alternating length bits
    push_word(8'h01, 16'h5555);
    push_word(8'hfe, 16'haaaa);
    push_word(8'h33, 16'd1);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_phase(PH_FREE, 0, 0, 400);
    run_phase(PH_PRESSURE, 0, 0, 250);
    run_phase(PH_SEND_IDLE, 85, 0, 400);
    run_phase(PH_RECV_STALL, 0, 85, 450);
    run_phase(PH_BOTH, 36, 36, 450);

    while (pending_words.size() != 0 || in_valid) @(posedge clk);
    while (hash_expected.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
